@@ rtl/pfb_pkg.sv @@
// Shared types and constants for the paged LCD framebuffer.
// No dependencies; imported by the top level.
package pfb_pkg;

    typedef logic [2:0] pfb_op_t;

    localparam pfb_op_t OP_SET_PIXEL     = 3'd0;
    localparam pfb_op_t OP_GET_PIXEL     = 3'd1;
    localparam pfb_op_t OP_FILL          = 3'd2;
    localparam pfb_op_t OP_START_REFRESH = 3'd3;
    localparam pfb_op_t OP_TICK          = 3'd4;

    // Display link command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] COL_LOW_MASK  = 8'h0F;
    localparam logic [7:0] PIXEL_MASK    = 8'h01;

    // Result kinds
    localparam logic RESULT_PIXEL = 1'b0;
    localparam logic RESULT_LINK  = 1'b1;

endpackage

@@ rtl/pfb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/paged_framebuffer_lcd_refresh.sv @@
// Paged monochrome LCD framebuffer with a frame refresh link; top level.
// Depends on pfb_pkg and pfb_ram.
//
// The framebuffer holds COLUMNS x PAGES bytes in one synchronous RAM; bit 0 of
// each byte is the top row of its page. The block works on one item at a
// time. set_pixel, get_pixel and tick read the RAM as they are accepted,
// then modify and write back or emit in an execute state; start_refresh
// and ignored opcodes are finished as they are accepted. fill sweeps the
// whole RAM one byte a cycle; the same sweep with value zero runs right
// after reset, so s_axis_tready rises once that sweep is done after rst_n
// is released. Configuration writes are taken at any time. Results go to an
// output register, so an item is accepted while a result still waits; an
// item that needs to emit holds in its execute state until the register frees.
// Each tick during an armed refresh emits one link byte: per page the page
// command, the column-high and column-low commands, then COLUMNS data bytes
// read from the store at that tick. tlast marks the final data byte of the
// frame.
module paged_framebuffer_lcd_refresh
    import pfb_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: column_offset
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // x_pos[7:0], y_pos[15:8], data_value[23:16]
    input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_bit[0], link_byte[8:1], zero[15:9]
    output logic [1:0]  m_axis_tuser,   // result_kind[0], is_command[1]
    output logic        m_axis_tlast    // frame_done
);

    localparam int STORE_DEPTH = COLUMNS * PAGES;
    localparam int ROWS        = PAGES * 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int POS_W       = $clog2(COLUMNS + 3);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [7:0]        fill_value_reg, fill_value_next;
    logic [7:0]        col_offset_reg;

    logic              refresh_active_reg, refresh_active_next;
    logic [PAGE_W-1:0] refresh_page_reg, refresh_page_next;
    logic [POS_W-1:0]  refresh_pos_reg, refresh_pos_next;

    // Latched item
    pfb_op_t           op_reg, op_next;
    logic              in_range_reg, in_range_next;
    logic [2:0]        bit_sel_reg, bit_sel_next;
    logic [7:0]        value_reg, value_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;
    logic              m_last_reg, m_last_next;

    // RAM ports
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    logic [7:0]        in_x, in_y, in_value;
    logic              in_accept;
    logic              pix_in_range;
    logic [ADDR_W-1:0] pix_addr;
    logic [COL_W-1:0]  refresh_col;
    logic [ADDR_W-1:0] refresh_addr;
    logic [7:0]        pix_mask;
    logic              emit;
    logic              out_free;

    assign in_x      = s_axis_tdata[7:0];
    assign in_y      = s_axis_tdata[15:8];
    assign in_value  = s_axis_tdata[23:16];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    assign pix_in_range = ({1'b0, in_x} < 9'(COLUMNS)) && ({1'b0, in_y} < 9'(ROWS));
    assign pix_addr     = ADDR_W'(in_y[7:3]) * ADDR_W'(COLUMNS) + ADDR_W'(in_x);

    // Data column of the current refresh position (positions 0..2 are commands)
    assign refresh_col  = COL_W'(refresh_pos_reg - POS_W'(3));
    assign refresh_addr = ADDR_W'(refresh_page_reg) * ADDR_W'(COLUMNS) + ADDR_W'(refresh_col);

    assign pix_mask = PIXEL_MASK << bit_sel_reg;

    // Does the item in execution produce a result?
    assign emit     = (state_reg == S_EXEC) &&
                      ((op_reg == OP_GET_PIXEL) || ((op_reg == OP_TICK) && refresh_active_reg));
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next          = state_reg;
        fill_addr_next      = fill_addr_reg;
        fill_value_next     = fill_value_reg;
        refresh_active_next = refresh_active_reg;
        refresh_page_next   = refresh_page_reg;
        refresh_pos_next    = refresh_pos_reg;
        op_next             = op_reg;
        in_range_next       = in_range_reg;
        bit_sel_next        = bit_sel_reg;
        value_next          = value_reg;
        addr_next           = addr_reg;
        m_valid_next        = m_valid_reg && !m_axis_tready;
        m_data_next         = m_data_reg;
        m_user_next         = m_user_reg;
        m_last_next         = m_last_reg;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = addr_reg;
        ram_wr_data         = 8'h00;
        ram_rd_en           = 1'b0;
        ram_rd_addr         = pix_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = s_axis_tuser;
                    in_range_next = pix_in_range;
                    bit_sel_next  = in_y[2:0];
                    value_next    = in_value;
                    addr_next     = pix_addr;
                    unique case (s_axis_tuser)
                        OP_SET_PIXEL, OP_GET_PIXEL:
                        begin
                            ram_rd_en  = 1'b1;
                            state_next = S_EXEC;
                        end
                        OP_TICK:
                        begin
                            // Fetch the data byte now; command positions ignore it
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = refresh_addr;
                            state_next  = S_EXEC;
                        end
                        OP_FILL:
                        begin
                            fill_addr_next  = '0;
                            fill_value_next = in_value;
                            state_next      = S_FILL;
                        end
                        OP_START_REFRESH:
                        begin
                            // Restart the frame even if one is running
                            refresh_active_next = 1'b1;
                            refresh_page_next   = '0;
                            refresh_pos_next    = '0;
                        end
                        default:
                        begin
                            // Unused opcodes: drop
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                // Hold while a result is due but the output register is taken
                if (!emit || out_free)
                begin
                    state_next = S_IDLE;
                    priority case (op_reg)
                        OP_SET_PIXEL:
                        begin
                            ram_wr_en   = in_range_reg;
                            ram_wr_data = (value_reg != 8'h00) ? (ram_rd_data | pix_mask)
                                                               : (ram_rd_data & ~pix_mask);
                        end
                        OP_GET_PIXEL:
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = {15'h0000,
                                            in_range_reg &&
                                            ((ram_rd_data & pix_mask) != 8'h00)};
                            m_user_next  = {1'b0, RESULT_PIXEL};
                            m_last_next  = 1'b0;
                        end
                        default:
                        begin
                            if (refresh_active_reg)
                            begin
                                m_valid_next = 1'b1;
                                m_last_next  = 1'b0;
                                priority if (refresh_pos_reg == POS_W'(0))
                                begin
                                    m_data_next = {7'h00,
                                                   CMD_PAGE_BASE | {4'h0, 4'(refresh_page_reg)},
                                                   1'b0};
                                    m_user_next = {1'b1, RESULT_LINK};
                                end
                                else if (refresh_pos_reg == POS_W'(1))
                                begin
                                    m_data_next = {7'h00,
                                                   CMD_COL_HIGH | {4'h0, col_offset_reg[7:4]},
                                                   1'b0};
                                    m_user_next = {1'b1, RESULT_LINK};
                                end
                                else if (refresh_pos_reg == POS_W'(2))
                                begin
                                    m_data_next = {7'h00, col_offset_reg & COL_LOW_MASK, 1'b0};
                                    m_user_next = {1'b1, RESULT_LINK};
                                end
                                else
                                begin
                                    m_data_next = {7'h00, ram_rd_data, 1'b0};
                                    m_user_next = {1'b0, RESULT_LINK};
                                end

                                // Advance position, page, and finish the frame
                                if (refresh_pos_reg == POS_W'(COLUMNS + 2))
                                begin
                                    refresh_pos_next = '0;
                                    if (refresh_page_reg == PAGE_W'(PAGES - 1))
                                    begin
                                        refresh_page_next   = '0;
                                        refresh_active_next = 1'b0;
                                        m_last_next         = 1'b1;
                                    end
                                    else
                                    begin
                                        refresh_page_next = PAGE_W'(refresh_page_reg + 1'b1);
                                    end
                                end
                                else
                                begin
                                    refresh_pos_next = POS_W'(refresh_pos_reg + 1'b1);
                                end
                            end
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = fill_addr_reg;
                ram_wr_data    = fill_value_reg;
                fill_addr_next = ADDR_W'(fill_addr_reg + 1'b1);
                if (fill_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset runs a clearing sweep with value zero
            state_reg          <= S_FILL;
            fill_addr_reg      <= '0;
            fill_value_reg     <= 8'h00;
            col_offset_reg     <= 8'd4;
            refresh_active_reg <= 1'b0;
            refresh_page_reg   <= '0;
            refresh_pos_reg    <= '0;
            m_valid_reg        <= 1'b0;
            op_reg             <= OP_SET_PIXEL;
        end
        else
        begin
            state_reg          <= state_next;
            fill_addr_reg      <= fill_addr_next;
            fill_value_reg     <= fill_value_next;
            refresh_active_reg <= refresh_active_next;
            refresh_page_reg   <= refresh_page_next;
            refresh_pos_reg    <= refresh_pos_next;
            m_valid_reg        <= m_valid_next;
            op_reg             <= op_next;
            if (cfg_wr_en)
            begin
                col_offset_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
        bit_sel_reg  <= bit_sel_next;
        value_reg    <= value_next;
        addr_reg     <= addr_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // The refresh position never runs past the last data byte of a page
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        refresh_pos_reg <= POS_W'(COLUMNS + 2))
        else $error("refresh position out of range");

    // The fill sweep advances one address per cycle once out of reset
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && $past(state_reg) == S_FILL && $past(rst_n))
            |-> fill_addr_reg == ADDR_W'($past(fill_addr_reg) + 1'b1))
        else $error("fill sweep skipped an address");

    // frame_done only rides on a display data byte
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == {1'b0, RESULT_LINK}))
        else $error("frame_done on a non-data result");

    // An accepted get_pixel always goes on to its execute state
    a_get_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tuser == OP_GET_PIXEL) |=> state_reg == S_EXEC)
        else $error("get_pixel not executed");

    // No store write in the execute state of any item but set_pixel
    a_no_write_on_get: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg != OP_SET_PIXEL) |-> !ram_wr_en)
        else $error("unexpected store write");

endmodule

@@ tb/paged_framebuffer_lcd_refresh_test.sv @@
// Self-checking testbench for the paged LCD framebuffer with refresh link.
// Depends on pfb_pkg and the paged_framebuffer_lcd_refresh RTL, which also needs pfb_ram.
// A directed table runs first, then random traffic under four idling phases.
module paged_framebuffer_lcd_refresh_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfb_pkg::*;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int ROWS    = PAGES * 8;
    localparam int STORE_BYTES = COLUMNS * PAGES;

    // A fill sweeps the whole store; give it that long plus margin before any
    // register write or the end of the run.
    localparam int FILL_CYCLES  = STORE_BYTES + 1;
    localparam int DRAIN_CYCLES = FILL_CYCLES + 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE  = 420;
    localparam int PHASES = 4;

    localparam logic [7:0] OFFSET_AT_RESET = 8'd4;
    localparam logic [7:0] OFFSET_MAX      = 8'd131;

    // Unused opcodes; the block must drop them silently.
    localparam pfb_op_t OP_RSVD_LO = 3'd5;
    localparam pfb_op_t OP_RSVD_HI = 3'd7;

    typedef struct packed {
        logic       kind;
        logic       pixel;
        logic [7:0] link;
        logic       cmd;
        logic       done;
    } lcd_result_t;

    // How a table row gets its expectation: from the predictor, typed in the
    // table, or none at all.
    typedef enum logic [1:0] {ROW_MODEL, ROW_GIVEN, ROW_SILENT} row_check_t;

    typedef struct packed {
        pfb_op_t     op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  v;
        row_check_t  chk;
        lcd_result_t given;
    } stim_row_t;

    localparam lcd_result_t PIXEL_ZERO = '{RESULT_PIXEL, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam lcd_result_t LINK_PAGE0 = '{RESULT_LINK, 1'b0, CMD_PAGE_BASE, 1'b1, 1'b0};
    localparam lcd_result_t LINK_COL_HIGH0 =
        '{RESULT_LINK, 1'b0, CMD_COL_HIGH | (OFFSET_AT_RESET >> 4), 1'b1, 1'b0};
    localparam lcd_result_t LINK_COL_LOW0 =
        '{RESULT_LINK, 1'b0, OFFSET_AT_RESET & COL_LOW_MASK, 1'b1, 1'b0};
    localparam lcd_result_t NO_RESULT = '0;

    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // cleared store reads zero; a tick with no refresh armed says nothing
        '{OP_GET_PIXEL,     8'd0,   8'd0,   8'd0,   ROW_GIVEN,  PIXEL_ZERO},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_SILENT, NO_RESULT},
        // corners of the panel
        '{OP_SET_PIXEL,     8'd0,   8'd0,   8'd1,   ROW_MODEL,  NO_RESULT},
        '{OP_SET_PIXEL,     8'd127, 8'd63,  8'hFF,  ROW_MODEL,  NO_RESULT},
        '{OP_GET_PIXEL,     8'd127, 8'd63,  8'd0,   ROW_MODEL,  NO_RESULT},
        '{OP_GET_PIXEL,     8'd0,   8'd0,   8'hFF,  ROW_MODEL,  NO_RESULT},
        // out-of-range coordinates: writes dropped, reads answer zero
        '{OP_SET_PIXEL,     8'd128, 8'd0,   8'd1,   ROW_MODEL,  NO_RESULT},
        '{OP_GET_PIXEL,     8'd128, 8'd0,   8'd0,   ROW_GIVEN,  PIXEL_ZERO},
        '{OP_GET_PIXEL,     8'd0,   8'd64,  8'd0,   ROW_GIVEN,  PIXEL_ZERO},
        '{OP_SET_PIXEL,     8'd255, 8'd255, 8'hFF,  ROW_MODEL,  NO_RESULT},
        '{OP_GET_PIXEL,     8'd255, 8'd255, 8'd0,   ROW_GIVEN,  PIXEL_ZERO},
        // clear a pixel again
        '{OP_SET_PIXEL,     8'd127, 8'd63,  8'd0,   ROW_MODEL,  NO_RESULT},
        '{OP_GET_PIXEL,     8'd127, 8'd63,  8'd0,   ROW_MODEL,  NO_RESULT},
        // unused opcodes
        '{OP_RSVD_LO,       8'hFF,  8'hFF,  8'hFF,  ROW_SILENT, NO_RESULT},
        '{OP_RSVD_HI,       8'h55,  8'hAA,  8'h5A,  ROW_SILENT, NO_RESULT},
        // page 0 header with the reset column offset, then the first data byte
        '{OP_START_REFRESH, 8'd0,   8'd0,   8'd0,   ROW_MODEL,  NO_RESULT},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_GIVEN,  LINK_PAGE0},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_GIVEN,  LINK_COL_HIGH0},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_GIVEN,  LINK_COL_LOW0},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_MODEL,  NO_RESULT},
        // store rewritten mid-frame; later data bytes must show it
        '{OP_FILL,          8'd0,   8'd0,   8'hA5,  ROW_MODEL,  NO_RESULT},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_MODEL,  NO_RESULT},
        // restart while a frame is running: back to the page 0 command
        '{OP_START_REFRESH, 8'd0,   8'd0,   8'd0,   ROW_MODEL,  NO_RESULT},
        '{OP_TICK,          8'd0,   8'd0,   8'd0,   ROW_GIVEN,  LINK_PAGE0},
        '{OP_GET_PIXEL,     8'd5,   8'd9,   8'd0,   ROW_MODEL,  NO_RESULT}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // x_pos[7:0], y_pos[15:8], data_value[23:16]
    logic [2:0]  s_axis_tuser;   // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // pixel_bit[0], link_byte[8:1], zero[15:9]
    logic [1:0]  m_axis_tuser;   // result_kind[0], is_command[1]
    logic        m_axis_tlast;   // frame_done

    paged_framebuffer_lcd_refresh #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Shadow of the framebuffer and refresh sequencer
    logic [7:0]  fb_bytes [STORE_BYTES];
    logic        refresh_on;
    int unsigned refresh_page;
    int unsigned refresh_pos;
    logic [7:0]  column_offset;

    lcd_result_t pending_results [$];

    int mismatches;
    int results_checked;
    int frames_sent;
    int items_sent;
    int fills_sent;
    int long_holds;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_request;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Advance the shadow by one accepted item; return 1 with the result it causes.
    function automatic bit framebuffer_step(input pfb_op_t op, input logic [7:0] x,
                                            input logic [7:0] y, input logic [7:0] v,
                                            output lcd_result_t res);
        bit          in_range;
        int unsigned addr;
        logic [7:0]  bit_mask;
        int unsigned col;

        in_range = (x < COLUMNS) && (y < ROWS);
        addr     = (y >> 3) * COLUMNS + x;
        bit_mask = PIXEL_MASK << y[2:0];
        res      = '0;
        case (op)
            OP_SET_PIXEL: begin
                if (in_range)
                    fb_bytes[addr] = (v != 0) ? (fb_bytes[addr] | bit_mask)
                                              : (fb_bytes[addr] & ~bit_mask);
                return 1'b0;
            end
            OP_GET_PIXEL: begin
                res.kind  = RESULT_PIXEL;
                res.pixel = in_range && ((fb_bytes[addr] & bit_mask) != 0);
                return 1'b1;
            end
            OP_FILL: begin
                foreach (fb_bytes[i])
                    fb_bytes[i] = v;
                return 1'b0;
            end
            OP_START_REFRESH: begin
                refresh_on   = 1'b1;
                refresh_page = 0;
                refresh_pos  = 0;
                return 1'b0;
            end
            OP_TICK: begin
                if (!refresh_on)
                    return 1'b0;
                res.kind = RESULT_LINK;
                res.cmd  = 1'b1;
                if (refresh_pos == 0)
                    res.link = CMD_PAGE_BASE | 8'(refresh_page & 15);
                else if (refresh_pos == 1)
                    res.link = CMD_COL_HIGH | (column_offset >> 4);
                else if (refresh_pos == 2)
                    res.link = column_offset & COL_LOW_MASK;
                else begin
                    col      = refresh_pos - 3;
                    res.link = fb_bytes[refresh_page * COLUMNS + col];
                    res.cmd  = 1'b0;
                end
                refresh_pos++;
                if (refresh_pos >= 3 + COLUMNS) begin
                    refresh_pos = 0;
                    refresh_page++;
                    if (refresh_page >= PAGES) begin
                        refresh_page = 0;
                        refresh_on   = 1'b0;
                        res.done     = 1'b1;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offer one item, idling first as the phase asks, and hold it until taken.
    // Returns at the accepting edge with tvalid still high.
    task automatic send_item(input pfb_op_t op, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] v, input row_check_t chk,
                             input lcd_result_t given);
        lcd_result_t predicted;
        bit          emits;

        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, y, x};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // Accepted at this edge: update the shadow in acceptance order.
        emits = framebuffer_step(op, x, y, v, predicted);
        items_sent++;
        if (op == OP_FILL)
            fills_sent++;
        if (chk == ROW_GIVEN)
            pending_results.push_back(given);
        else if (chk == ROW_MODEL && emits)
            pending_results.push_back(predicted);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Drop input and wait for every outstanding result, then let a fill finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        lcd_result_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: tdata 0x%0h tuser 0x%0h tlast %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.kind, m_axis_tuser[0]);
                check_field("pixel_bit", want.pixel, m_axis_tdata[0]);
                check_field("link_byte", want.link, m_axis_tdata[8:1]);
                check_field("is_command", want.cmd, m_axis_tuser[1]);
                check_field("frame_done", want.done, m_axis_tlast);
                check_field("tdata padding", 0, m_axis_tdata[15:9]);
                results_checked++;
                if (want.done)
                    frames_sent++;
            end
        end
    end

    // Receiver: random stalls per phase, plus one long hold-off on request so
    // the output register and the pipeline back up into the input.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_request = 1'b0;
                long_holds++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int          ph;
        int          counted;
        int unsigned pick;
        pfb_op_t     op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  v;
        logic [7:0]  new_offset;
        bit          ignored;
        int          idle_by_phase  [PHASES];
        int          stall_by_phase [PHASES];
        logic [7:0]  offset_by_phase [PHASES];

        idle_by_phase   = '{0, 81, 0, 31};
        stall_by_phase  = '{0, 0, 81, 31};
        offset_by_phase = '{8'd0, OFFSET_MAX, 8'd124, 8'd0};

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request  = 1'b0;

        foreach (fb_bytes[i])
            fb_bytes[i] = 8'h00;
        refresh_on    = 1'b0;
        refresh_page  = 0;
        refresh_pos   = 0;
        column_offset = OFFSET_AT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, reset column offset
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].op, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].v,
                      DIRECTED[r].chk, DIRECTED[r].given);

        for (ph = 0; ph < PHASES; ph++) begin
            settle();

            // New column offset while idle; a refresh may still be armed, so the
            // next column commands must pick it up mid-frame.
            new_offset = (ph == PHASES - 1) ? 8'($urandom_range(OFFSET_MAX))
                                            : offset_by_phase[ph];
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= new_offset;
            @(posedge clk);
            column_offset = new_offset;
            cfg_wr_en <= 1'b0;

            sender_idle_pct    = idle_by_phase[ph];
            receiver_stall_pct = stall_by_phase[ph];

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(999);
                // Mostly well-formed refresh runs: arm when idle, then tick
                // through the frame with pixel traffic mixed in.
                if (!refresh_on && $urandom_range(9) == 0)
                    op = OP_START_REFRESH;
                else if (pick < 740)
                    op = OP_TICK;
                else if (pick < 840)
                    op = OP_SET_PIXEL;
                else if (pick < 940)
                    op = OP_GET_PIXEL;
                else if (pick < 955)
                    op = OP_FILL;
                else if (pick < 970)
                    op = pfb_op_t'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
                else if (pick < 975 && refresh_page == 0)
                    op = OP_START_REFRESH;   // broken run: restart early in a frame
                else
                    op = OP_TICK;

                if ($urandom_range(99) < 85) begin
                    x = 8'($urandom_range(COLUMNS - 1));
                    y = 8'($urandom_range(ROWS - 1));
                end else begin
                    x = 8'($urandom_range(255));
                    y = 8'($urandom_range(255));
                end

                pick = $urandom_range(99);
                if (op == OP_SET_PIXEL)
                    v = (pick < 30) ? 8'h00 : 8'($urandom_range(255, 1));
                else if (op == OP_FILL)
                    v = (pick < 20) ? 8'h00 : (pick < 40) ? 8'hFF : 8'($urandom_range(255));
                else
                    v = 8'($urandom_range(255));

                ignored = (op == OP_TICK && !refresh_on) || (op > OP_TICK);
                send_item(op, x, y, v, ROW_MODEL, NO_RESULT);
                if (!ignored)
                    counted++;

                // Back-pressure test: the receiver holds off while items keep coming.
                if (ph == 0 && counted == 100 && !ignored)
                    hold_request = 1'b1;
            end
        end

        settle();

        $display("Sent %0d items (%0d fills), checked %0d results, %0d complete frames,",
                 items_sent, fills_sent, results_checked, frames_sent);
        $display("four idling phases, %0d long receiver hold-off(s), %0d mismatches.",
                 long_holds, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
